FILE: rtl/core/gmw_pkg.sv
package gmw_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int KERNEL_SIZE_DEF = 7;

    // Fixed window geometry: a 7x7 window, centre three rows and three columns back.
    localparam int WIN     = 7;
    localparam int LAG     = 3;
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 56;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LAST = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 4'd7;

    // Depth of the result queue in front of the output port.
    localparam int FIFO_DEPTH = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    typedef logic [PIX_W-1:0] pix_t;

    // One window or line-buffer entry: the sample and whether it belongs to the frame.
    typedef struct packed {
        pix_t pix;
        logic vld;
    } tap_t;

    // Partial erosion and dilation values.
    typedef struct packed {
        pix_t ero;
        pix_t dil;
    } ed_t;

endpackage

FILE: rtl/core/grayscale_morphology_window.sv
// Streaming 7x7 grayscale erosion and dilation with a programmable non-flat
// structuring element. Pixels enter in raster order, one transaction per clock
// at most, on the input channel (in_valid/in_stall). Each accepted pixel yields
// zero or one result on the output channel (out_valid/out_stall) carrying the
// erosion, the dilation and the centre position, three rows and three columns
// behind the input; the host flushes the tail of a frame with padding items.
// The weights and line width are written through the cfg channel, which is always
// ready; write them only while the block is idle, which the block does not enforce.
// Throughput is one pixel per clock while in_stall is low, set by the shift of
// the 7x7 cell array and one read plus one write per cycle on each of the six
// line-buffer RAMs. After the edge that accepts its pixel, a result passes the
// registers of the per-cell weighting, the row reduction, the window reduction
// and the write into the result queue before it reaches out_valid.
// The result queue is eight deep; in_stall rises when the queued results plus
// the pixels in flight reach eight, so a stalled receiver backs up the input
// once the queue holds four results with four pixels still in the pipeline.
// Reset clears counters, valid flags, weights and sets the line width to its
// maximum; line-buffer contents are not cleared, because the row count since
// the frame start masks every stale entry.
module grayscale_morphology_window #(
    parameter int MAX_WIDTH   = gmw_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE = gmw_pkg::KERNEL_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Pixel input channel.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gmw_pkg::PIX_W-1:0]        pixel,
    input  logic                             frame_start,
    input  logic                             is_padding,
    // Result output channel.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gmw_pkg::PIX_W-1:0]        eroded,
    output logic [gmw_pkg::PIX_W-1:0]        dilated,
    output logic [$clog2(MAX_WIDTH)-1:0]     out_col,
    output logic [gmw_pkg::ROW_W-1:0]        out_row,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gmw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int LW_W    = COL_W + 1;
    localparam int WIN     = gmw_pkg::WIN;
    localparam int LAG     = gmw_pkg::LAG;
    localparam int RAD     = (KERNEL_SIZE / 2 > LAG) ? LAG : KERNEL_SIZE / 2;
    localparam int FDEPTH  = gmw_pkg::FIFO_DEPTH;
    localparam int FPTR_W  = $clog2(FDEPTH);
    localparam int FCNT_W  = $clog2(FDEPTH + 1);
    localparam int OCC_W   = FCNT_W + 1;
    localparam int ROWS_W  = $clog2(WIN);
    localparam int LB_NUM  = WIN - 1;
    localparam int TAP_W   = $bits(gmw_pkg::tap_t);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [gmw_pkg::CFG_DATA_W-1:0] weights_reg [WIN];
    logic [LW_W-1:0]                line_width_reg;
    logic [LW_W-1:0]                line_width_next;
    logic [10:0]                    cfg_lw_raw;

    assign cfg_ready  = 1'b1;
    assign cfg_lw_raw = cfg_data[10:0];

    // The written width is saturated into the legal range.
    always_comb
    begin
        priority if (32'(cfg_lw_raw) < 32'(KERNEL_SIZE))
        begin
            line_width_next = LW_W'(KERNEL_SIZE);
        end
        else if (32'(cfg_lw_raw) > 32'(MAX_WIDTH))
        begin
            line_width_next = LW_W'(MAX_WIDTH);
        end
        else
        begin
            line_width_next = LW_W'(cfg_lw_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                weights_reg[i] <= '0;
            end
            line_width_reg <= LW_W'(MAX_WIDTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index <= gmw_pkg::REG_WEIGHTS_LAST)
            begin
                weights_reg[cfg_index[ROWS_W-1:0]] <= cfg_data;
            end
            else if (cfg_index == gmw_pkg::REG_LINE_WIDTH)
            begin
                line_width_reg <= line_width_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and position counters.
    // ------------------------------------------------------------------
    logic                 accept;
    logic [COL_W-1:0]     col_count_reg;
    logic [COL_W-1:0]     col_count_next;
    logic [gmw_pkg::ROW_W-1:0] row_count_reg;
    logic [gmw_pkg::ROW_W-1:0] row_count_next;
    logic [ROWS_W-1:0]    rows_seen_reg;
    logic [ROWS_W-1:0]    rows_seen_next;
    logic [COL_W-1:0]     cur_col;
    logic [gmw_pkg::ROW_W-1:0] cur_row;
    logic [ROWS_W-1:0]    cur_rows;
    logic [LW_W-1:0]      col_inc;
    logic                 row_wrap;
    logic [LW_W-1:0]      centre_col_wide;
    logic [COL_W-1:0]     centre_col;
    logic [gmw_pkg::ROW_W-1:0] centre_row;
    logic [COL_W-1:0]     lb_raddr;

    assign accept = in_valid && !in_stall;

    // A frame start returns the counters to the top-left corner before the
    // item is handled.
    assign cur_col  = frame_start ? '0 : col_count_reg;
    assign cur_row  = frame_start ? '0 : row_count_reg;
    assign cur_rows = frame_start ? '0 : rows_seen_reg;

    assign col_inc  = {1'b0, cur_col} + LW_W'(1);
    assign row_wrap = (col_inc >= line_width_reg);

    always_comb
    begin
        col_count_next = row_wrap ? '0 : col_inc[COL_W-1:0];
        row_count_next = row_wrap ? cur_row + gmw_pkg::ROW_W'(1) : cur_row;
        rows_seen_next = (row_wrap && (cur_rows != ROWS_W'(LB_NUM)))
                         ? cur_rows + ROWS_W'(1) : cur_rows;
    end

    // Centre of the window: three columns back, wrapping into the previous row.
    always_comb
    begin
        if (cur_col >= COL_W'(LAG))
        begin
            centre_col_wide = {1'b0, cur_col} - LW_W'(LAG);
            centre_row      = cur_row - gmw_pkg::ROW_W'(LAG);
        end
        else
        begin
            centre_col_wide = {1'b0, cur_col} + line_width_reg - LW_W'(LAG);
            centre_row      = cur_row - gmw_pkg::ROW_W'(LAG + 1);
        end
        centre_col = centre_col_wide[COL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            rows_seen_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            rows_seen_reg <= rows_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers. All six share the column counter as address, so each one
    // delays its input by exactly one image row. The read address runs one
    // item ahead so the registered read data is ready at the next transaction.
    // ------------------------------------------------------------------
    gmw_pkg::tap_t lb_rd [1:LB_NUM];
    gmw_pkg::tap_t lb_wr [1:LB_NUM];
    gmw_pkg::tap_t in_tap;

    assign in_tap.pix = pixel;
    assign in_tap.vld = !is_padding;
    assign lb_raddr   = accept ? col_count_next : col_count_reg;

    generate
        for (genvar k = 1; k <= LB_NUM; k++)
        begin : g_lb
            logic [TAP_W-1:0] rdata;

            if (k == 1)
            begin : g_first
                assign lb_wr[k] = in_tap;
            end
            else
            begin : g_next
                assign lb_wr[k] = lb_rd[k-1];
            end

            gmw_ram #(
                .WIDTH (TAP_W),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .clk   (clk),
                .we    (accept),
                .waddr (cur_col),
                .wdata (lb_wr[k]),
                .raddr (lb_raddr),
                .rdata (rdata)
            );

            assign lb_rd[k] = rdata;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Centre-position pipeline. Stage 0 follows the window shift, stage 1
    // the per-cell weighting, stage 2 the row reduction, stage 3 the final one.
    // ------------------------------------------------------------------
    logic                      s_vld_reg  [4];
    logic                      s_keep_reg [1:3];
    logic [COL_W-1:0]          s_col_reg  [4];
    logic [gmw_pkg::ROW_W-1:0] s_row_reg  [4];
    logic [WIN-1:0]            col_ok;

    // Column range check of each window column around the stage-0 centre.
    generate
        for (genvar c = 0; c < WIN; c++)
        begin : g_colok
            if (c < LAG)
            begin : g_left
                assign col_ok[c] = ({1'b0, s_col_reg[0]} >= LW_W'(LAG - c));
            end
            else
            begin : g_right
                assign col_ok[c] = (({1'b0, s_col_reg[0]} + LW_W'(c - LAG))
                                    < line_width_reg);
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // The 7x7 cell array. Column WIN-1 takes the newest sample of its row;
    // each cell hands its sample to the left neighbor on every transaction.
    // Row WIN-1 is the current image row, row 0 the oldest.
    // ------------------------------------------------------------------
    gmw_pkg::tap_t cell_q   [WIN][WIN];
    gmw_pkg::tap_t cell_din [WIN][WIN];
    gmw_pkg::ed_t  cell_ed  [WIN][WIN];
    gmw_pkg::ed_t  row_ed   [WIN];
    gmw_pkg::ed_t  win_ed;

    generate
        for (genvar r = 0; r < WIN; r++)
        begin : g_row
            for (genvar c = 0; c < WIN; c++)
            begin : g_col
                localparam int DR = (r > LAG) ? r - LAG : LAG - r;
                localparam int DC = (c > LAG) ? c - LAG : LAG - c;
                localparam bit TAP_ON = (DR <= RAD) && (DC <= RAD);

                if (c == WIN - 1)
                begin : g_entry
                    if (r == WIN - 1)
                    begin : g_cur
                        assign cell_din[r][c] = in_tap;
                    end
                    else
                    begin : g_buf
                        // Rows above the top of the frame are not part of it.
                        assign cell_din[r][c].pix = lb_rd[WIN-1-r].pix;
                        assign cell_din[r][c].vld = lb_rd[WIN-1-r].vld
                                                    && (cur_rows >= ROWS_W'(WIN-1-r));
                    end
                end
                else
                begin : g_inner
                    // A frame start drops every older sample from the window.
                    assign cell_din[r][c].pix = cell_q[r][c+1].pix;
                    assign cell_din[r][c].vld = cell_q[r][c+1].vld && !frame_start;
                end

                gmw_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (accept),
                    .din      (cell_din[r][c]),
                    .q        (cell_q[r][c]),
                    .weight   (weights_reg[r][8*c +: 8]),
                    .use_tap  (col_ok[c] && TAP_ON),
                    .result   (cell_ed[r][c])
                );
            end

            gmw_minmax #(
                .N (WIN)
            ) u_row_mm (
                .clk  (clk),
                .din  (cell_ed[r]),
                .dout (row_ed[r])
            );
        end
    endgenerate

    gmw_minmax #(
        .N (WIN)
    ) u_win_mm (
        .clk  (clk),
        .din  (row_ed),
        .dout (win_ed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s_vld_reg[0] <= accept;
            for (int i = 1; i < 4; i++)
            begin
                s_vld_reg[i] <= s_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_col_reg[0] <= centre_col;
            s_row_reg[0] <= centre_row;
        end
        // A result exists only when the centre sample is an image pixel.
        s_keep_reg[1] <= cell_q[LAG][LAG].vld;
        s_keep_reg[2] <= s_keep_reg[1];
        s_keep_reg[3] <= s_keep_reg[2];
        for (int i = 1; i < 4; i++)
        begin
            s_col_reg[i] <= s_col_reg[i-1];
            s_row_reg[i] <= s_row_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Result queue. Input is held off when the queue plus everything in
    // flight could overflow it, so no result is ever dropped.
    // ------------------------------------------------------------------
    gmw_pkg::ed_t              fifo_ed_reg  [FDEPTH];
    logic [COL_W-1:0]          fifo_col_reg [FDEPTH];
    logic [gmw_pkg::ROW_W-1:0] fifo_row_reg [FDEPTH];
    logic [FPTR_W-1:0]         wr_ptr_reg;
    logic [FPTR_W-1:0]         rd_ptr_reg;
    logic [FCNT_W-1:0]         fifo_cnt_reg;
    logic                      push;
    logic                      pop;
    logic [OCC_W-1:0]          occupancy;

    assign push = s_vld_reg[3] && s_keep_reg[3];
    assign pop  = out_valid && !out_stall;

    assign occupancy = OCC_W'(fifo_cnt_reg) + OCC_W'(s_vld_reg[0]) + OCC_W'(s_vld_reg[1])
                       + OCC_W'(s_vld_reg[2]) + OCC_W'(s_vld_reg[3]);
    assign in_stall  = (occupancy >= OCC_W'(FDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + FCNT_W'(1);
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - FCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_ed_reg[wr_ptr_reg]  <= win_ed;
            fifo_col_reg[wr_ptr_reg] <= s_col_reg[3];
            fifo_row_reg[wr_ptr_reg] <= s_row_reg[3];
        end
    end

    assign out_valid = (fifo_cnt_reg != '0);
    assign eroded    = fifo_ed_reg[rd_ptr_reg].ero;
    assign dilated   = fifo_ed_reg[rd_ptr_reg].dil;
    assign out_col   = fifo_col_reg[rd_ptr_reg];
    assign out_row   = fifo_row_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/gmw_ram.sv
module gmw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/gmw_cell.sv
module gmw_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  gmw_pkg::tap_t din,
    output gmw_pkg::tap_t q,
    input  gmw_pkg::pix_t weight,
    input  logic          use_tap,
    output gmw_pkg::ed_t  result
);

    gmw_pkg::pix_t pix_reg;
    logic          vld_reg;
    gmw_pkg::ed_t  result_reg;
    gmw_pkg::ed_t  result_next;
    logic [gmw_pkg::PIX_W:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            pix_reg <= din.pix;
        end
        result_reg <= result_next;
    end

    // An excluded tap contributes the neutral value to both reductions.
    always_comb
    begin
        sum = {1'b0, pix_reg} + {1'b0, weight};
        if (vld_reg && use_tap)
        begin
            result_next.ero = (pix_reg > weight) ? (pix_reg - weight) : gmw_pkg::PIX_MIN;
            result_next.dil = sum[gmw_pkg::PIX_W] ? gmw_pkg::PIX_MAX
                                                  : sum[gmw_pkg::PIX_W-1:0];
        end
        else
        begin
            result_next.ero = gmw_pkg::PIX_MAX;
            result_next.dil = gmw_pkg::PIX_MIN;
        end
    end

    assign q.pix  = pix_reg;
    assign q.vld  = vld_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/gmw_minmax.sv
module gmw_minmax #(
    parameter int N = 7
) (
    input  logic         clk,
    input  gmw_pkg::ed_t din [N],
    output gmw_pkg::ed_t dout
);

    gmw_pkg::ed_t dout_reg;
    gmw_pkg::ed_t dout_next;

    always_comb
    begin
        dout_next = din[0];
        for (int i = 1; i < N; i++)
        begin
            if (din[i].ero < dout_next.ero)
            begin
                dout_next.ero = din[i].ero;
            end
            if (din[i].dil > dout_next.dil)
            begin
                dout_next.dil = din[i].dil;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the streaming 7x7 grayscale erosion/dilation block.
//
// A scoreboard model of the window runs inside the testbench. It is fed each input
// transaction at the moment the block accepts it, and it queues the result that the
// block must produce. The monitor takes results off the output channel and compares
// them field by field with the oldest queued result.
//
// The run has three phases with different idle patterns on the two channels. The
// structuring weights and the line width are reprogrammed between phases, the width
// also between some frames, but only after every queued result has come out.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING      = gmw_pkg::WIN * gmw_pkg::MAX_WIDTH_DEF;
    localparam int COL_W     = $clog2(gmw_pkg::MAX_WIDTH_DEF);
    localparam int PIX_W     = gmw_pkg::PIX_W;
    localparam int ROW_W     = gmw_pkg::ROW_W;
    localparam int IDX_W     = gmw_pkg::CFG_IDX_W;
    localparam int DATA_W    = gmw_pkg::CFG_DATA_W;
    localparam int WIN       = gmw_pkg::WIN;
    localparam int LAG       = gmw_pkg::LAG;
    localparam int TIMEOUT   = 600000;
    localparam int DRAIN_CYC = 12;
    localparam int PHASE_ITEMS = 560;

    // One input transaction.
    typedef struct {
        logic [PIX_W-1:0] pix;
        bit               fs;
        bit               pad;
    } pix_item_t;

    // One output transaction.
    typedef struct {
        logic [PIX_W-1:0] ero;
        logic [PIX_W-1:0] dil;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } morph_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  frame_start = 1'b0;
    logic                  is_padding = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      eroded;
    logic [PIX_W-1:0]      dilated;
    logic [COL_W-1:0]      out_col;
    logic [ROW_W-1:0]      out_row;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;

    grayscale_morphology_window dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .frame_start(frame_start),
        .is_padding (is_padding),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .eroded     (eroded),
        .dilated    (dilated),
        .out_col    (out_col),
        .out_row    (out_row),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Scoreboard copy of the block state: the weights, the line width and a ring
    // holding the last seven lines together with a flag telling whether each slot
    // holds a real pixel of the current frame.
    logic [DATA_W-1:0]     weight_rows [WIN];
    int                    line_w;
    logic [PIX_W-1:0]      ring_pix [RING];
    bit                    ring_ok [RING];
    int                    wr_ptr;
    int                    col_cnt;
    int                    row_cnt;

    pix_item_t  pending_pix [$];
    morph_res_t expected_res [$];

    int idle_in_pct;
    int stall_out_pct;
    int err_count;
    int res_count;
    int frame_count;
    int cycle_count;

    // Mirrors a register write. Unknown indexes are ignored, and the line width
    // saturates into the range that the window supports.
    function automatic void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        int v;
        if (idx <= gmw_pkg::REG_WEIGHTS_LAST)
        begin
            weight_rows[idx] = val;
        end
        else if (idx == gmw_pkg::REG_LINE_WIDTH)
        begin
            v = int'(val[10:0]);
            if (v < gmw_pkg::KERNEL_SIZE_DEF)
                v = gmw_pkg::KERNEL_SIZE_DEF;
            if (v > gmw_pkg::MAX_WIDTH_DEF)
                v = gmw_pkg::MAX_WIDTH_DEF;
            line_w = v;
        end
    endfunction

    // Advances the window by one accepted pixel and queues the result, if any.
    // The centre sits three rows and three columns behind the newest pixel.
    function automatic void step_window(pix_item_t it);
        int cc, cr, off, idx, col, p, wt, e, d;
        int lo, hi;
        morph_res_t r;
        lo = 255;
        hi = 0;
        if (it.fs)
        begin
            foreach (ring_ok[i])
                ring_ok[i] = 1'b0;
            col_cnt = 0;
            row_cnt = 0;
        end
        wr_ptr = (wr_ptr + 1) % RING;
        ring_pix[wr_ptr] = it.pix;
        ring_ok[wr_ptr] = !it.pad;
        if (col_cnt >= LAG)
        begin
            cc = col_cnt - LAG;
            cr = (row_cnt - LAG) & 12'hFFF;
        end
        else
        begin
            cc = col_cnt + line_w - LAG;
            cr = (row_cnt - LAG - 1) & 12'hFFF;
        end
        col_cnt++;
        if (col_cnt >= line_w)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 12'hFFF;
        end
        off = LAG * line_w + LAG;
        if (!ring_ok[(wr_ptr + RING - off) % RING])
            return;
        for (int dr = -LAG; dr <= LAG; dr++)
        begin
            for (int dc = -LAG; dc <= LAG; dc++)
            begin
                col = cc + dc;
                if (col < 0 || col >= line_w)
                    continue;
                off = (LAG - dr) * line_w + (LAG - dc);
                idx = (wr_ptr + RING - off) % RING;
                if (!ring_ok[idx])
                    continue;
                p = int'(ring_pix[idx]);
                wt = int'(weight_rows[LAG + dr][8 * (LAG + dc) +: 8]);
                e = (p - wt < 0) ? 0 : p - wt;
                d = (p + wt > 255) ? 255 : p + wt;
                if (e < lo)
                    lo = e;
                if (d > hi)
                    hi = d;
            end
        end
        r.ero = lo[PIX_W-1:0];
        r.dil = hi[PIX_W-1:0];
        r.col = cc[COL_W-1:0];
        r.row = cr[ROW_W-1:0];
        expected_res.push_back(r);
    endfunction

    // Driver. A payload that is stalled stays put; otherwise the next pending pixel
    // goes out unless the sender decides to idle this cycle. The scoreboard sees
    // each transaction on the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                step_window('{pix: pixel, fs: frame_start, pad: is_padding});
            if (!(in_valid && in_stall))
            begin
                if (pending_pix.size() > 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    pixel       <= pending_pix[0].pix;
                    frame_start <= pending_pix[0].fs;
                    is_padding  <= pending_pix[0].pad;
                    in_valid    <= 1'b1;
                    void'(pending_pix.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. It stalls the output at random and checks every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        morph_res_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                res_count++;
                if (expected_res.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result ero=%0d dil=%0d col=%0d row=%0d",
                             $realtime, eroded, dilated, out_col, out_row);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (eroded !== want.ero)
                    begin
                        err_count++;
                        $display("%0t: eroded expected %0d actual %0d",
                                 $realtime, want.ero, eroded);
                    end
                    if (dilated !== want.dil)
                    begin
                        err_count++;
                        $display("%0t: dilated expected %0d actual %0d",
                                 $realtime, want.dil, dilated);
                    end
                    if (out_col !== want.col)
                    begin
                        err_count++;
                        $display("%0t: out_col expected %0d actual %0d",
                                 $realtime, want.col, out_col);
                    end
                    if (out_row !== want.row)
                    begin
                        err_count++;
                        $display("%0t: out_row expected %0d actual %0d",
                                 $realtime, want.row, out_row);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_out_pct);
        end
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT)
        begin
            $display("%0t: timeout with %0d pixels pending and %0d results expected",
                     $realtime, pending_pix.size(), expected_res.size());
            $display("** grayscale_morphology_window: FAILED **");
            $finish;
        end
    end

    // One register write through the configuration channel.
    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Waits until the pipeline has nothing left to do, then drains further so that
    // pixels which produce no result have also left the window.
    task automatic wait_idle();
        while (pending_pix.size() > 0 || in_valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(5))
            0: return gmw_pkg::PIX_MIN;
            1: return gmw_pkg::PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Queues one frame of the current line width, optionally sprinkled with stray
    // padding items and restarts, then the padding that flushes its last rows.
    // Returns the number of transactions queued.
    function automatic int queue_frame(int rows, bit noisy);
        pix_item_t it;
        int n;
        n = 0;
        for (int i = 0; i < rows * line_w; i++)
        begin
            it.pix = rand_pix();
            it.fs  = (i == 0) || (noisy && $urandom_range(199) == 0);
            it.pad = noisy && $urandom_range(49) == 0;
            pending_pix.push_back(it);
            n++;
        end
        for (int i = 0; i < LAG * line_w + LAG + $urandom_range(4); i++)
        begin
            it.pix = PIX_W'($urandom);
            it.fs  = 1'b0;
            it.pad = 1'b1;
            pending_pix.push_back(it);
            n++;
        end
        frame_count++;
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] rand_weights();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return DATA_W'({$urandom, $urandom});
        endcase
    endfunction

    initial
    begin
        pix_item_t it;
        int random_pix;
        err_count   = 0;
        res_count   = 0;
        frame_count = 0;
        cycle_count = 0;
        idle_in_pct   = 15;
        stall_out_pct = 45;
        foreach (weight_rows[i])
            weight_rows[i] = '0;
        line_w  = gmw_pkg::MAX_WIDTH_DEF;
        wr_ptr  = 0;
        col_cnt = 0;
        row_cnt = 0;
        foreach (ring_ok[i])
        begin
            ring_ok[i]  = 1'b0;
            ring_pix[i] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: the narrowest line (a width of zero saturates up to seven),
        // weights at both extremes and pixels cycling through white, black and mid-grey,
        // so that both clamps and the frame edges are hit.
        cfg_write(gmw_pkg::REG_LINE_WIDTH, '0);
        for (int r = 0; r < WIN; r++)
            cfg_write(IDX_W'(r), (r % 2 == 0) ? '1 : '0);
        for (int i = 0; i < 4 * line_w; i++)
        begin
            it.pix = (i % 3 == 0) ? gmw_pkg::PIX_MAX
                                  : ((i % 3 == 1) ? gmw_pkg::PIX_MIN : 8'h80);
            it.fs  = (i == 0);
            it.pad = (i == 9);
            pending_pix.push_back(it);
        end
        for (int i = 0; i < LAG * line_w + LAG; i++)
            pending_pix.push_back('{pix: 8'hFF, fs: 1'b0, pad: 1'b1});
        wait_idle();

        // Writes to indexes that name no register must change nothing.
        cfg_write(4'd8, '1);
        cfg_write(4'd15, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_in_pct   = (phase == 0) ? 15 : ((phase == 1) ? 45 : 0);
            stall_out_pct = (phase == 0) ? 45 : ((phase == 1) ? 15 : 0);
            wait_idle();
            for (int r = 0; r < WIN; r++)
                cfg_write(IDX_W'(r), rand_weights());
            // Random upper data bits are ignored by the width register.
            cfg_write(gmw_pkg::REG_LINE_WIDTH,
                      DATA_W'({$urandom, $urandom}) & {{(DATA_W-11){1'b1}}, 11'h0}
                      | DATA_W'($urandom_range(7, 24)));
            random_pix = 0;
            while (random_pix < PHASE_ITEMS)
            begin
                random_pix += queue_frame($urandom_range(4, 12), $urandom_range(2) != 0);
                // Switch to another small width between frames now and then.
                if ($urandom_range(3) == 0)
                begin
                    wait_idle();
                    cfg_write(gmw_pkg::REG_LINE_WIDTH, DATA_W'($urandom_range(7, 24)));
                end
            end
        end

        wait_idle();

        $display("Covered %0d frames at line widths 7..24 with %0d results checked,",
                 frame_count, res_count);
        $display("under input idling, output stalls and stray padding/restart items.");
        if (err_count == 0)
            $display("** grayscale_morphology_window: PASSED **");
        else
            $display("** grayscale_morphology_window: FAILED **");
        $finish;
    end

endmodule
